// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TSS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TSS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tss_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes and constants of the task slot scheduler.
// No dependencies.
package tss_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int SLOT_W        = 4;
  localparam int WOKEN_W       = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'd1;

  localparam logic POL_RR   = 1'b0;
  localparam logic POL_FCFS = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_RESCHED  = 3'd1,
    CMD_CREATE   = 3'd2,
    CMD_BLOCK    = 3'd3,
    CMD_WAKE_ONE = 3'd4,
    CMD_WAKE_ALL = 3'd5,
    CMD_EXIT     = 3'd6,
    CMD_REAP     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    SL_UNUSED  = 3'd0,
    SL_READY   = 3'd1,
    SL_RUNNING = 3'd2,
    SL_BLOCKED = 3'd3,
    SL_ZOMBIE  = 3'd4
  } slot_state_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_FIN1,
    FSM_FIN2,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    slot_state_t  state;
    logic [31:0]  stamp;
    logic [15:0]  ticks;
    logic [15:0]  wait_id;
  } entry_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [15:0]        channel;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    logic               switched;
    logic [SLOT_W-1:0]  current_slot;
    logic [SLOT_W-1:0]  result_slot;
    logic [WOKEN_W-1:0] woken_count;
    logic               ok;
  } rsp_t;

endpackage

// ===== hdl/task_slot_scheduler.sv =====
`timescale 1ns / 1ps
// Task slot scheduler: slot table in one synchronous memory, scanned per command.
// Depends on tss_pkg.
//
//  port group   dir   handshake            payload
//  req          in    req_valid/req_stall  req_data (cmd, channel, slot)
//  rsp          out   rsp_valid/rsp_stall  rsp_data (switched .. ok)
//  cfg          in    cfg_we               cfg_index, cfg_data
//
// A command is taken only in FSM_IDLE: it is scanned with one read per slot (plus read
// latency), written back in FSM_FIN1 and FSM_FIN2, and its result is loaded in FSM_OUT.
// A new command is not taken before the result of the last one is loaded.
// After reset the slot memory is cleared; req_stall stays high meanwhile.
// The result register frees the scan: a new command is taken while a result waits.
// A stalled result holds the block before its next result load.
module task_slot_scheduler
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int DW = IW + 1;
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam int CW = IW + SLOT_W;

  entry_t mem [NUM_SLOTS];
  entry_t rd_data;

  fsm_t           state, state_next;
  logic [DW-1:0]  cnt;
  logic           dat_vld;
  logic [IW-1:0]  dat_idx;
  req_t           req_q;
  logic [IW-1:0]  running;
  logic [31:0]    stamp;
  logic [LW-1:0]  live;
  logic           policy;
  logic [15:0]    quantum;
  logic           done;
  logic           ok_q;
  logic [IW-1:0]  res_q;
  logic [WOKEN_W-1:0] woken_q;
  entry_t         cur_e;
  logic           best_found;
  logic [IW-1:0]  best_idx;
  logic [31:0]    best_stamp;
  logic [15:0]    best_wait;
  logic [DW-1:0]  best_dist;
  logic           any_rdy;
  logic           nxt_we;
  logic [IW-1:0]  cur_e_slot_q;

  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  entry_t         mem_wdata;
  logic [IW-1:0]  rd_addr;
  logic           load_out;

  logic [15:0]    q;
  entry_t         m;
  logic           hit, hit_res, hit_stamp;
  logic [DW-1:0]  rr_gap;
  logic           better;
  logic [31:0]    s_new;
  logic           disp_req, forced, cur_run, go, dec;
  logic           cur_cand, pick_cur;
  logic [31:0]    cur_stamp;
  logic           cur_we;
  entry_t         cur_wdata;
  entry_t         clr_entry;
  cmd_t           cmd;

  assign q     = (quantum == 16'd0) ? 16'd1 : quantum;
  assign s_new = stamp + 32'd1;
  assign cmd   = cmd_t'(req_q.cmd);

  // scan: per-entry modify
  always_comb begin
    m         = rd_data;
    hit       = 1'b0;
    hit_res   = 1'b0;
    hit_stamp = 1'b0;
    case (cmd)
      CMD_CREATE: begin
        if (!done && live < LW'(NUM_SLOTS) && dat_idx != '0 &&
            rd_data.state == SL_UNUSED) begin
          m.state   = SL_READY;
          m.stamp   = s_new;
          m.ticks   = q;
          m.wait_id = '0;
          hit       = 1'b1;
          hit_res   = 1'b1;
          hit_stamp = 1'b1;
        end
      end
      CMD_WAKE_ONE, CMD_WAKE_ALL: begin
        if (!(cmd == CMD_WAKE_ONE && done) && dat_idx != '0 &&
            rd_data.state == SL_BLOCKED && rd_data.wait_id == req_q.channel) begin
          m.state   = SL_READY;
          m.stamp   = s_new;
          m.wait_id = '0;
          hit       = 1'b1;
          hit_res   = 1'b1;
          hit_stamp = 1'b1;
        end
      end
      CMD_BLOCK: begin
        if (dat_idx == running && running != '0 && rd_data.state == SL_RUNNING) begin
          m.state   = SL_BLOCKED;
          m.wait_id = req_q.channel;
          hit       = 1'b1;
        end
      end
      CMD_EXIT: begin
        if (dat_idx == running && running != '0 && rd_data.state == SL_RUNNING) begin
          m.state = SL_ZOMBIE;
          hit     = 1'b1;
        end
      end
      CMD_REAP: begin
        if (CW'(dat_idx) == CW'(req_q.slot) && dat_idx != '0 && dat_idx != running &&
            rd_data.state == SL_ZOMBIE) begin
          m.state   = SL_UNUSED;
          m.stamp   = '0;
          m.ticks   = '0;
          m.wait_id = '0;
          hit       = 1'b1;
          hit_res   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // scan: candidate ranking
  always_comb begin
    if (dat_idx > running) begin
      rr_gap = {1'b0, dat_idx} - {1'b0, running} - DW'(1);
    end else begin
      rr_gap = {1'b0, dat_idx} + DW'(NUM_SLOTS) - {1'b0, running} - DW'(1);
    end
    if (policy == POL_FCFS) begin
      better = !best_found || (m.stamp < best_stamp);
    end else begin
      better = !best_found || (rr_gap < best_dist);
    end
  end

  // finish: dispatch decision
  always_comb begin
    disp_req = (cmd == CMD_TICK) || (cmd == CMD_RESCHED) ||
               (((cmd == CMD_BLOCK) || (cmd == CMD_EXIT)) && ok_q);
    forced   = (cmd != CMD_TICK);
    cur_run  = (cur_e.state == SL_RUNNING);
    go       = disp_req && (live > LW'(1)) &&
               (forced || !((running != '0 && cur_run &&
                             (policy == POL_FCFS || cur_e.ticks > 16'd1)) ||
                            (running == '0 && !any_rdy)));
    dec      = disp_req && (live > LW'(1)) && !forced && policy == POL_RR &&
               running != '0 && cur_run && cur_e.ticks > 16'd1;
    cur_cand  = cur_run || (cur_e.state == SL_READY);
    cur_stamp = cur_run ? s_new : cur_e.stamp;
    pick_cur  = cur_cand &&
                (!best_found ||
                 (policy == POL_FCFS &&
                  ((cur_stamp < best_stamp) ||
                   (cur_stamp == best_stamp && running < best_idx))));
    cur_we    = 1'b0;
    cur_wdata = cur_e;
    if (dec) begin
      cur_we          = 1'b1;
      cur_wdata.ticks = cur_e.ticks - 16'd1;
    end else if (go && pick_cur) begin
      cur_we          = 1'b1;
      cur_wdata.state = SL_RUNNING;
      cur_wdata.stamp = cur_stamp;
      cur_wdata.ticks = q;
    end else if (go && cur_run) begin
      cur_we          = 1'b1;
      cur_wdata.state = SL_READY;
      cur_wdata.stamp = s_new;
    end
  end

  always_comb begin
    clr_entry = '0;
    if (cnt == '0) begin
      clr_entry.state = SL_RUNNING;
      clr_entry.stamp = 32'd1;
      clr_entry.ticks = QUANTUM_RESET;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FSM_CLEAR: if (cnt == DW'(NUM_SLOTS - 1)) state_next = FSM_IDLE;
      FSM_IDLE:  if (req_valid) state_next = FSM_SCAN;
      FSM_SCAN:  if (cnt == DW'(NUM_SLOTS)) state_next = FSM_FIN1;
      FSM_FIN1:  state_next = FSM_FIN2;
      FSM_FIN2:  state_next = FSM_OUT;
      FSM_OUT:   if (!rsp_valid || !rsp_stall) state_next = FSM_IDLE;
      default:   state_next = FSM_CLEAR;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    req_stall = (state != FSM_IDLE);
    load_out  = (state == FSM_OUT) && (!rsp_valid || !rsp_stall);
    rd_addr   = cnt[IW-1:0];
    mem_we    = 1'b0;
    mem_waddr = dat_idx;
    mem_wdata = m;
    case (state)
      FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = clr_entry;
      end
      FSM_SCAN: begin
        mem_we = dat_vld;
      end
      FSM_FIN1: begin
        mem_we    = cur_we;
        mem_waddr = running;
        mem_wdata = cur_wdata;
      end
      FSM_FIN2: begin
        mem_we    = nxt_we;
        mem_waddr = best_idx;
        mem_wdata = '{state: SL_RUNNING, stamp: best_stamp, ticks: q,
                      wait_id: best_wait};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_CLEAR;
      cnt       <= '0;
      dat_vld   <= 1'b0;
      running   <= '0;
      stamp     <= 32'd1;
      live      <= LW'(1);
      policy    <= POL_RR;
      quantum   <= QUANTUM_RESET;
      rsp_valid <= 1'b0;
      nxt_we    <= 1'b0;
    end else begin
      state   <= state_next;
      dat_vld <= (state == FSM_SCAN) && (cnt < DW'(NUM_SLOTS));
      dat_idx <= cnt[IW-1:0];

      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY:  policy  <= cfg_data[0];
          REG_QUANTUM: quantum <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        FSM_CLEAR: begin
          cnt <= (cnt == DW'(NUM_SLOTS - 1)) ? '0 : cnt + DW'(1);
        end
        FSM_IDLE: begin
          if (req_valid) begin
            req_q      <= req_data;
            cnt        <= '0;
            done       <= 1'b0;
            ok_q       <= 1'b0;
            res_q      <= '0;
            woken_q    <= '0;
            best_found <= 1'b0;
            any_rdy    <= 1'b0;
          end
        end
        FSM_SCAN: begin
          if (cnt < DW'(NUM_SLOTS)) begin
            cnt <= cnt + DW'(1);
          end
          if (dat_vld) begin
            if (hit) begin
              done <= 1'b1;
              ok_q <= 1'b1;
              if (hit_res && !ok_q) begin
                res_q <= dat_idx;
              end
              if (hit_stamp) begin
                stamp   <= s_new;
                woken_q <= woken_q + WOKEN_W'(1);
              end
              if (cmd == CMD_CREATE) begin
                live <= live + LW'(1);
              end else if (cmd == CMD_REAP && live != '0) begin
                live <= live - LW'(1);
              end
            end
            if (dat_idx == running) begin
              cur_e <= m;
            end else if (m.state == SL_READY) begin
              if (dat_idx != '0) begin
                any_rdy <= 1'b1;
              end
              if (better) begin
                best_found <= 1'b1;
                best_idx   <= dat_idx;
                best_stamp <= m.stamp;
                best_wait  <= m.wait_id;
                best_dist  <= rr_gap;
              end
            end
          end
        end
        FSM_FIN1: begin
          nxt_we <= go && best_found && !pick_cur;
          if (go && cur_run) begin
            stamp <= s_new;
          end
          if (go && best_found && !pick_cur) begin
            running <= best_idx;
          end
        end
        FSM_FIN2: begin
          nxt_we <= 1'b0;
        end
        default: ;
      endcase

      if (load_out) begin
        rsp_valid             <= 1'b1;
        rsp_data.switched     <= (running != cur_e_slot_q);
        rsp_data.current_slot <= SLOT_W'(running);
        rsp_data.result_slot  <= SLOT_W'(res_q);
        rsp_data.woken_count  <= (cmd == CMD_WAKE_ALL) ? woken_q : '0;
        rsp_data.ok           <= (cmd == CMD_TICK || cmd == CMD_RESCHED) ? 1'b1 : ok_q;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // slot that was current when the command was taken
  always_ff @(posedge clk) begin
    if (state == FSM_IDLE) begin
      cur_e_slot_q <= running;
    end
  end

endmodule

// ===== hdl/tss_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the task slot scheduler, bound to the top level.
// Depends on tss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tss_checker
  import tss_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_data
);

  `TSS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")
  `TSS_ASSERT(a_busy_after_take, clk, rst, req_valid && !req_stall |=> req_stall, "command taken while busy")
  `TSS_ASSERT(a_fail_clean, clk, rst, rsp_valid && !rsp_data.ok |-> rsp_data.result_slot == '0 && rsp_data.woken_count == '0, "failed command reports a slot")
  `TSS_ASSERT(a_clear_stall, clk, rst, $fell(rst) |-> req_stall, "command taken during clear")

endmodule

bind task_slot_scheduler tss_checker u_tss_checker (.*);
